FILE: sv/mrte_pkg.sv
// ----------------------------------------------------------------------------
// mrte_pkg
// shared types, codes and alphabets of the multi-radix text encoder
// ----------------------------------------------------------------------------
package mrte_pkg;

    typedef enum logic [2:0] {
        MODE_B64    = 3'd0,
        MODE_B64URL = 3'd1,
        MODE_B32    = 3'd2,
        MODE_B32HEX = 3'd3,
        MODE_B16    = 3'd4,
        MODE_BITS_M = 3'd5,
        MODE_BITS_L = 3'd6,
        MODE_Z85    = 3'd7
    } mode_t;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_WRAP = 1'b1;

    localparam logic [11:0] WRAP_RESET = 12'd76;
    localparam logic [11:0] COL_MAX    = 12'hFFF;
    localparam logic [7:0]  CHAR_NL    = 8'h0A;
    localparam logic [7:0]  CHAR_PAD   = 8'h3D;

    // floor(w / 85) == (w * Z85_MAGIC) >> 38 for every 32-bit w
    localparam logic [31:0] Z85_MAGIC = 32'hC0C0C0C1;

    localparam logic [8*85-1:0] Z85_ALPHA =
        {"0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ",
         ".-:+=^!/*?&<>()[]{}@%$#"};

    // one unit of work for the back end: the characters of one input transaction
    typedef struct packed {
        mode_t       mode;
        logic [39:0] bits;    // symbols left-aligned; z85 word in [31:0]
        logic [3:0]  nchars;  // encoded characters, the rest up to total is padding
        logic [3:0]  total;
        logic        eos;     // close with the final newline
        logic        err;
    } job_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v, input logic url);
        logic [7:0] c;
        if (v < 6'd26)      c = 8'h41 + 8'(v);
        else if (v < 6'd52) c = 8'h61 + 8'(v - 6'd26);
        else if (v < 6'd62) c = 8'h30 + 8'(v - 6'd52);
        else if (v == 6'd62) c = url ? 8'h2D : 8'h2B;
        else                c = url ? 8'h5F : 8'h2F;
        return c;
    endfunction

    function automatic logic [7:0] b32_char(input logic [4:0] v, input logic hex);
        logic [7:0] c;
        if (hex) c = (v < 5'd10) ? 8'h30 + 8'(v) : 8'h41 + 8'(v - 5'd10);
        else     c = (v < 5'd26) ? 8'h41 + 8'(v) : 8'h32 + 8'(v - 5'd26);
        return c;
    endfunction

    function automatic logic [7:0] b16_char(input logic [3:0] v);
        return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h41 + 8'(v - 4'd10);
    endfunction

    function automatic logic [7:0] z85_char(input logic [6:0] d);
        return Z85_ALPHA[8*(84 - 32'(d)) +: 8];
    endfunction

endpackage

FILE: sv/mrte_front.sv
// ----------------------------------------------------------------------------
// mrte_front
// collects bytes into groups and turns each transaction into a job
// ----------------------------------------------------------------------------
module mrte_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mrte_pkg::mode_t       mode,
    input  logic                  clear_group,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  has_byte,
    input  logic                  end_of_stream,
    output logic                  push,
    output mrte_pkg::job_t        job
);

    logic [31:0] group_reg, group_next;
    logic [2:0]  count_reg, count_next;
    logic [2:0]  gsize;
    logic        full;
    logic [31:0] gb_upd;
    logic [2:0]  cnt_upd;
    logic [39:0] v40;

    always_comb begin
        unique case (mode)
            mrte_pkg::MODE_B64, mrte_pkg::MODE_B64URL: gsize = 3'd3;
            mrte_pkg::MODE_B32, mrte_pkg::MODE_B32HEX: gsize = 3'd5;
            mrte_pkg::MODE_Z85:                        gsize = 3'd4;
            default:                                   gsize = 3'd1;
        endcase
    end

    assign full = has_byte && ({1'b0, count_reg} + 4'd1 >= {1'b0, gsize});
    assign v40  = {group_reg, data_byte};

    always_comb begin
        gb_upd  = group_reg;
        cnt_upd = count_reg;
        if (has_byte) begin
            if (full) begin
                gb_upd  = '0;
                cnt_upd = '0;
            end else begin
                gb_upd  = {group_reg[23:0], data_byte};
                cnt_upd = count_reg + 3'd1;
            end
        end
    end

    always_comb begin
        job.mode   = mode;
        job.bits   = '0;
        job.nchars = '0;
        job.total  = '0;
        job.eos    = end_of_stream;
        job.err    = (mode == mrte_pkg::MODE_Z85) && end_of_stream && (cnt_upd != 3'd0);
        if (full) begin
            case (mode)
                mrte_pkg::MODE_B64, mrte_pkg::MODE_B64URL: begin
                    job.bits = {v40[23:0], 16'd0};
                    job.nchars = 4'd4;
                end
                mrte_pkg::MODE_B32, mrte_pkg::MODE_B32HEX: begin
                    job.bits = v40;
                    job.nchars = 4'd8;
                end
                mrte_pkg::MODE_B16: begin
                    job.bits = {data_byte, 32'd0};
                    job.nchars = 4'd2;
                end
                mrte_pkg::MODE_BITS_M: begin
                    job.bits = {data_byte, 32'd0};
                    job.nchars = 4'd8;
                end
                mrte_pkg::MODE_BITS_L: begin
                    // bit 0 goes out first
                    job.bits = {data_byte[0], data_byte[1], data_byte[2], data_byte[3],
                                data_byte[4], data_byte[5], data_byte[6], data_byte[7],
                                32'd0};
                    job.nchars = 4'd8;
                end
                default: begin
                    job.bits = {8'd0, v40[31:0]};
                    job.nchars = 4'd5;
                end
            endcase
            job.total = job.nchars;
        end else if (cnt_upd != 3'd0) begin
            // partial group flushed at end of stream
            case (mode)
                mrte_pkg::MODE_B64, mrte_pkg::MODE_B64URL: begin
                    job.total = 4'd4;
                    if (cnt_upd == 3'd1) begin
                        job.bits = {gb_upd[7:0], 32'd0};
                        job.nchars = 4'd2;
                    end else begin
                        job.bits = {gb_upd[15:0], 24'd0};
                        job.nchars = 4'd3;
                    end
                end
                mrte_pkg::MODE_B32, mrte_pkg::MODE_B32HEX: begin
                    job.total = 4'd8;
                    case (cnt_upd)
                        3'd1:    begin job.bits = {gb_upd[7:0], 32'd0};  job.nchars = 4'd2; end
                        3'd2:    begin job.bits = {gb_upd[15:0], 24'd0}; job.nchars = 4'd4; end
                        3'd3:    begin job.bits = {gb_upd[23:0], 16'd0}; job.nchars = 4'd5; end
                        default: begin job.bits = {gb_upd, 8'd0};        job.nchars = 4'd7; end
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign push = accept && (full || end_of_stream);

    always_comb begin
        group_next = group_reg;
        count_next = count_reg;
        if (clear_group) begin
            group_next = '0;
            count_next = '0;
        end else if (accept) begin
            group_next = end_of_stream ? 32'd0 : gb_upd;
            count_next = end_of_stream ? 3'd0 : cnt_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_reg <= '0;
            count_reg <= '0;
        end else begin
            group_reg <= group_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: sv/mrte_fifo.sv
// ----------------------------------------------------------------------------
// mrte_fifo
// two-entry job queue between front and back end
// ----------------------------------------------------------------------------
module mrte_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  mrte_pkg::job_t  push_job,
    input  logic            pop,
    output mrte_pkg::job_t  head,
    output logic            not_empty,
    output logic            not_full
);

    mrte_pkg::job_t slot_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign head      = slot_reg[rd_reg];
    assign not_empty = cnt_reg != 2'd0;
    assign not_full  = cnt_reg != 2'd2;

    always_comb begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_reg] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: sv/mrte_back.sv
// ----------------------------------------------------------------------------
// mrte_back
// runs jobs: z85 digit extraction, character emission, line wrapping
// ----------------------------------------------------------------------------
module mrte_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [11:0]     wrap_columns,
    input  mrte_pkg::job_t  head,
    input  logic            not_empty,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_char,
    output logic            m_run_last,
    output logic            m_stream_done,
    output logic            m_length_error
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_SUB  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    mrte_pkg::job_t  job_reg, job_next;
    logic [3:0]      idx_reg, idx_next;
    logic [11:0]     col_reg, col_next;
    logic [31:0]     w_reg, w_next;
    logic [63:0]     prod_reg, prod_next;
    logic [2:0]      k_reg, k_next;
    logic [6:0]      dig_reg [5];
    logic            dig_we;
    logic [25:0]     quot;
    logic [31:0]     rem_full;
    logic            out_free, emit, finish;
    logic [7:0]      sym_char, ch_next;
    logic            last_next, done_next, err_next;
    logic            valid_reg;
    logic [7:0]      char_reg;
    logic            last_reg, done_reg, err_reg;

    assign out_free = !valid_reg || m_ready;
    assign quot     = prod_reg[63:38];
    assign rem_full = w_reg - 32'(quot) * 32'd85;

    always_comb begin
        case (job_reg.mode)
            mrte_pkg::MODE_B64, mrte_pkg::MODE_B64URL:
                sym_char = mrte_pkg::b64_char(job_reg.bits[39:34],
                                              job_reg.mode == mrte_pkg::MODE_B64URL);
            mrte_pkg::MODE_B32, mrte_pkg::MODE_B32HEX:
                sym_char = mrte_pkg::b32_char(job_reg.bits[39:35],
                                              job_reg.mode == mrte_pkg::MODE_B32HEX);
            mrte_pkg::MODE_B16:
                sym_char = mrte_pkg::b16_char(job_reg.bits[39:36]);
            mrte_pkg::MODE_BITS_M, mrte_pkg::MODE_BITS_L:
                sym_char = job_reg.bits[39] ? 8'h31 : 8'h30;
            default:
                sym_char = mrte_pkg::z85_char(dig_reg[idx_reg[2:0]]);
        endcase
    end

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        idx_next   = idx_reg;
        col_next   = col_reg;
        w_next     = w_reg;
        prod_next  = prod_reg;
        k_next     = k_reg;
        dig_we     = 1'b0;
        emit       = 1'b0;
        finish     = 1'b0;
        pop        = 1'b0;
        ch_next    = mrte_pkg::CHAR_NL;
        last_next  = 1'b0;
        done_next  = 1'b0;
        err_next   = 1'b0;

        unique case (state_reg)
            ST_IDLE: ;
            ST_MUL: begin
                prod_next  = {32'd0, w_reg} * {32'd0, mrte_pkg::Z85_MAGIC};
                state_next = ST_SUB;
            end
            ST_SUB: begin
                dig_we     = 1'b1;
                w_next     = 32'(quot);
                k_next     = k_reg + 3'd1;
                state_next = (k_reg == 3'd4) ? ST_EMIT : ST_MUL;
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (idx_reg < job_reg.total) begin
                        if (wrap_columns != 12'd0 && col_reg >= wrap_columns) begin
                            col_next = '0;
                        end else begin
                            ch_next  = (idx_reg < job_reg.nchars) ? sym_char
                                                                  : mrte_pkg::CHAR_PAD;
                            col_next = (col_reg != mrte_pkg::COL_MAX) ? col_reg + 12'd1
                                                                      : col_reg;
                            idx_next = idx_reg + 4'd1;
                            job_next.bits = job_reg.bits << (
                                (job_reg.mode == mrte_pkg::MODE_B64 ||
                                 job_reg.mode == mrte_pkg::MODE_B64URL) ? 6 :
                                (job_reg.mode == mrte_pkg::MODE_B32 ||
                                 job_reg.mode == mrte_pkg::MODE_B32HEX) ? 5 :
                                (job_reg.mode == mrte_pkg::MODE_B16) ? 4 : 1);
                            if (idx_reg + 4'd1 == job_reg.total && !job_reg.eos) begin
                                last_next = 1'b1;
                                finish    = 1'b1;
                            end
                        end
                    end else begin
                        col_next  = '0;
                        last_next = 1'b1;
                        done_next = 1'b1;
                        err_next  = job_reg.err;
                        finish    = 1'b1;
                    end
                    if (finish) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // next job starts right behind the last character of the current one
        if ((state_reg == ST_IDLE || finish) && not_empty) begin
            pop      = 1'b1;
            job_next = head;
            idx_next = '0;
            w_next   = head.bits[31:0];
            k_next   = '0;
            state_next = (head.mode == mrte_pkg::MODE_Z85 && head.total != 4'd0)
                         ? ST_MUL : ST_EMIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (dig_we) dig_reg[3'd4 - k_reg] <= rem_full[6:0];
        job_reg  <= job_next;
        idx_reg  <= idx_next;
        w_reg    <= w_next;
        prod_reg <= prod_next;
        k_reg    <= k_next;
        if (emit) begin
            char_reg <= ch_next;
            last_reg <= last_next;
            done_reg <= done_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            if (emit)         valid_reg <= 1'b1;
            else if (m_ready) valid_reg <= 1'b0;
        end
    end

    assign m_valid        = valid_reg;
    assign m_out_char     = char_reg;
    assign m_run_last     = last_reg;
    assign m_stream_done  = done_reg;
    assign m_length_error = err_reg;

endmodule

FILE: sv/multi_radix_text_encoder_top.sv
// ----------------------------------------------------------------------------
// multi_radix_text_encoder_top
// byte stream to base64/base64url/base32/base32hex/base16/bit string/z85 text
// ----------------------------------------------------------------------------
// Each input transaction carries at most one byte and an end-of-stream mark.
// The front end collects bytes into groups (3 for base64, 5 for base32, 4 for
// z85, 1 otherwise) and hands each completed or flushed group as a job to a
// two-entry queue; the back end sends one character per cycle on the m_ port
// while the receiver is ready and no z85 digit extraction runs, inserting wrap
// newlines and the final newline that closes every stream. An item causes up
// to 17 characters, wrap and final newlines included; a z85 group first has its
// five digits extracted on the shared 32x32 reciprocal multiplier, each digit
// in a multiply step and a subtract step. Items that cause no output are taken
// whenever the queue has room. Writes to register 0 (encoding mode) drop any
// pending partial group; register 1 sets the wrap width, 0 turning wrapping off.
// ----------------------------------------------------------------------------
module multi_radix_text_encoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data,
    // byte input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_has_byte,
    input  logic        s_end_of_stream,
    // character output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_run_last,
    output logic        m_stream_done,
    output logic        m_length_error
);

    mrte_pkg::mode_t mode_reg;
    logic [11:0]     wrap_reg;
    logic            cfg_fire, s_fire, clear_group;
    logic            push, pop, not_empty, not_full;
    mrte_pkg::job_t  push_job, head;

    // config is always taken; the user must send it only while the block is idle, the block does not check this itself
    assign cfg_ready   = 1'b1;
    assign cfg_fire    = cfg_valid && cfg_ready;
    assign clear_group = cfg_fire && cfg_index == mrte_pkg::CFG_MODE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= mrte_pkg::MODE_B64;
            wrap_reg <= mrte_pkg::WRAP_RESET;
        end else if (cfg_fire) begin
            if (cfg_index == mrte_pkg::CFG_MODE) mode_reg <= mrte_pkg::mode_t'(cfg_data[2:0]);
            else                                 wrap_reg <= cfg_data;
        end
    end

    // accept whenever the queue has a free slot, even if this item makes no job
    assign s_ready = not_full;
    assign s_fire  = s_valid && s_ready;

    mrte_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .mode          (mode_reg),
        .clear_group   (clear_group),
        .accept        (s_fire),
        .data_byte     (s_data_byte),
        .has_byte      (s_has_byte),
        .end_of_stream (s_end_of_stream),
        .push          (push),
        .job           (push_job)
    );

    mrte_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .not_full  (not_full)
    );

    // back end owns the column count and the output register
    mrte_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .wrap_columns   (wrap_reg),
        .head           (head),
        .not_empty      (not_empty),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_char     (m_out_char),
        .m_run_last     (m_run_last),
        .m_stream_done  (m_stream_done),
        .m_length_error (m_length_error)
    );

endmodule

FILE: sv/mrte_checker.sv
// ----------------------------------------------------------------------------
// mrte_checker
// port-level checks on the encoder output
// ----------------------------------------------------------------------------
module mrte_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_char,
    input logic       m_run_last,
    input logic       m_stream_done,
    input logic       m_length_error
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_char))
        else $error("output transaction dropped or changed while stalled");

    a_done_nl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stream_done |-> m_out_char == 8'h0A && m_run_last)
        else $error("stream end is not a final newline");

    a_err_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_length_error |-> m_stream_done)
        else $error("length error away from stream end");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

bind multi_radix_text_encoder_top mrte_checker u_mrte_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_out_char     (m_out_char),
    .m_run_last     (m_run_last),
    .m_stream_done  (m_stream_done),
    .m_length_error (m_length_error)
);

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the multi-radix text encoder
// ----------------------------------------------------------------------------
// A directed table covers the corner cases: empty streams, padding, z85 length
// errors, wrapping, mode and wrap-width writes. Random streams follow, in every
// mode and at several wrap widths. A behavioral encoder predicts each output
// character, and every output transaction is checked against the oldest
// expected character.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // expected output character with its flags
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       done;
        logic       err;
    } char_exp_t;

    // one row of the directed table
    // when chk is set, the first expected character is also compared with ech
    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] val;
        logic        has;
        logic        eos;
        logic        chk;
        logic [7:0]  ech;
    } row_t;

    localparam logic [1:0] ROW_BYTE = 2'd0;
    localparam logic [1:0] ROW_MODE = 2'd1;
    localparam logic [1:0] ROW_WRAP = 2'd2;

    localparam int TIMEOUT_CYCLES = 400000;
    localparam int DRAIN_CYCLES   = 40;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = 1'b0;
    logic [11:0] cfg_data = '0;
    logic        cfg_ready;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data_byte = '0;
    logic        s_has_byte = 1'b0;
    logic        s_end_of_stream = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_char;
    logic        m_run_last;
    logic        m_stream_done;
    logic        m_length_error;

    multi_radix_text_encoder_top dut (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    // predictor state
    mrte_pkg::mode_t enc_mode = mrte_pkg::MODE_B64;
    logic [11:0] wrap_cols = mrte_pkg::WRAP_RESET;
    logic [31:0] grp_bytes = '0;
    int          grp_cnt = 0;
    logic [11:0] col_cnt = '0;

    char_exp_t   pending_chars[$];
    char_exp_t   item_chars[$];
    int          error_count = 0;
    int          cycle_count = 0;
    logic        stall_en = 1'b0;

    string A64  = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    string A64U = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
    string A32  = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
    string A32H = "0123456789ABCDEFGHIJKLMNOPQRSTUV";
    string A16  = "0123456789ABCDEF";
    string AZ85 =
        "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // one encoded character, with a wrap newline ahead of it when the line is full
    function automatic void put_char(input logic [7:0] c);
        if (wrap_cols != 0 && col_cnt >= wrap_cols) begin
            item_chars.push_back('{mrte_pkg::CHAR_NL, 1'b0, 1'b0, 1'b0});
            col_cnt = '0;
        end
        item_chars.push_back('{c, 1'b0, 1'b0, 1'b0});
        if (col_cnt < mrte_pkg::COL_MAX) col_cnt++;
    endfunction

    function automatic logic [7:0] sym64(input logic [5:0] v);
        return (enc_mode == mrte_pkg::MODE_B64URL) ? A64U[v] : A64[v];
    endfunction

    function automatic logic [7:0] sym32(input logic [4:0] v);
        return (enc_mode == mrte_pkg::MODE_B32HEX) ? A32H[v] : A32[v];
    endfunction

    function automatic void encode_group(input logic [39:0] v);
        logic [31:0] w;
        int          dig[5];
        case (enc_mode)
            mrte_pkg::MODE_B64, mrte_pkg::MODE_B64URL: begin
                for (int i = 0; i < 4; i++) put_char(sym64(v[23-6*i -: 6]));
            end
            mrte_pkg::MODE_B32, mrte_pkg::MODE_B32HEX: begin
                for (int i = 0; i < 8; i++) put_char(sym32(v[39-5*i -: 5]));
            end
            mrte_pkg::MODE_B16: begin
                put_char(A16[v[7:4]]);
                put_char(A16[v[3:0]]);
            end
            mrte_pkg::MODE_BITS_M: begin
                for (int i = 7; i >= 0; i--) put_char(v[i] ? "1" : "0");
            end
            mrte_pkg::MODE_BITS_L: begin
                for (int i = 0; i < 8; i++) put_char(v[i] ? "1" : "0");
            end
            default: begin
                w = v[31:0];
                for (int i = 4; i >= 0; i--) begin
                    dig[i] = w % 85;
                    w = w / 85;
                end
                for (int i = 0; i < 5; i++) put_char(AZ85[dig[i]]);
            end
        endcase
    endfunction

    // end-of-stream flush of a partial group; returns the z85 length error
    function automatic logic flush_group();
        logic [39:0] v;
        int          nch;
        if (grp_cnt == 0) return 1'b0;
        case (enc_mode)
            mrte_pkg::MODE_B64, mrte_pkg::MODE_B64URL: begin
                v = 40'(grp_bytes) << (8 * (3 - grp_cnt));
                nch = grp_cnt + 1;
                for (int i = 0; i < 4; i++)
                    put_char(i < nch ? sym64(v[23-6*i -: 6]) : mrte_pkg::CHAR_PAD);
            end
            mrte_pkg::MODE_B32, mrte_pkg::MODE_B32HEX: begin
                v = 40'(grp_bytes) << (8 * (5 - grp_cnt));
                nch = (8 * grp_cnt + 4) / 5;
                for (int i = 0; i < 8; i++)
                    put_char(i < nch ? sym32(v[39-5*i -: 5]) : mrte_pkg::CHAR_PAD);
            end
            mrte_pkg::MODE_Z85: return 1'b1;
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic int group_len();
        case (enc_mode)
            mrte_pkg::MODE_B64, mrte_pkg::MODE_B64URL: return 3;
            mrte_pkg::MODE_B32, mrte_pkg::MODE_B32HEX: return 5;
            mrte_pkg::MODE_Z85:                        return 4;
            default:                                   return 1;
        endcase
    endfunction

    // predicts the characters of one input transaction into item_chars
    function automatic void predict_item(input logic [7:0] b, input logic has,
                                         input logic eos);
        logic err;
        item_chars.delete();
        if (has) begin
            if (grp_cnt + 1 >= group_len()) begin
                encode_group({grp_bytes, b});
                grp_bytes = '0;
                grp_cnt = 0;
            end else begin
                grp_bytes = {grp_bytes[23:0], b};
                grp_cnt++;
            end
        end
        if (eos) begin
            err = flush_group();
            item_chars.push_back('{mrte_pkg::CHAR_NL, 1'b0, 1'b1, err});
            grp_bytes = '0;
            grp_cnt = 0;
            col_cnt = '0;
        end
        if (item_chars.size() > 0) item_chars[$].last = 1'b1;
    endfunction

    // sends one input transaction and queues what it should produce
    // valid stays high so the next call can follow with no gap
    task automatic send_byte(input logic [7:0] b, input logic has, input logic eos);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_has_byte <= has;
        s_end_of_stream <= eos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_item(b, has, eos);
        foreach (item_chars[i]) pending_chars.push_back(item_chars[i]);
    endtask

    // ends a burst
    task automatic idle_input();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // stops sending, waits until every queued character has come out, plus a gap
    task automatic wait_quiet();
        idle_input();
        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // register write, only issued while the block is idle
    task automatic write_reg(input logic idx, input logic [11:0] val);
        wait_quiet();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == mrte_pkg::CFG_MODE) begin
            enc_mode = mrte_pkg::mode_t'(val[2:0]);
            grp_bytes = '0;
            grp_cnt = 0;
        end else begin
            wrap_cols = val;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // output checker
    always @(posedge aclk) begin
        char_exp_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char %02h", m_out_char));
            end else begin
                e = pending_chars.pop_front();
                if (m_out_char !== e.ch || m_run_last !== e.last ||
                    m_stream_done !== e.done || m_length_error !== e.err)
                    report_mismatch($sformatf(
                        "got %02h/%b%b%b exp %02h/%b%b%b", m_out_char, m_run_last,
                        m_stream_done, m_length_error, e.ch, e.last, e.done, e.err));
            end
        end
    end

    // receiver stall pattern: a random run of stalls, switched on and off
    always @(negedge aclk) begin
        if (!stall_en) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    row_t dir_rows[$];

    // runs one directed row; a typed-in first character is checked as well
    task automatic run_row(input row_t r);
        case (r.kind)
            ROW_MODE: write_reg(mrte_pkg::CFG_MODE, r.val);
            ROW_WRAP: write_reg(mrte_pkg::CFG_WRAP, r.val);
            default: begin
                send_byte(r.val[7:0], r.has, r.eos);
                if (r.chk && (item_chars.size() == 0 || item_chars[0].ch !== r.ech))
                    report_mismatch($sformatf("directed row predicts wrong first char"));
            end
        endcase
    endtask

    initial begin
        int n_items;
        int len;
        int burst;
        // empty stream right after reset: only the final newline
        dir_rows.push_back('{ROW_BYTE, 12'h000, 1'b0, 1'b1, 1'b1, mrte_pkg::CHAR_NL});
        // item with neither byte nor end causes nothing
        dir_rows.push_back('{ROW_BYTE, 12'h0AB, 1'b0, 1'b0, 1'b0, 8'h00});
        // base64 one byte 0xFF padded at end: "/w=="
        dir_rows.push_back('{ROW_BYTE, 12'h0FF, 1'b1, 1'b1, 1'b1, "/"});
        dir_rows.push_back('{ROW_BYTE, 12'h000, 1'b1, 1'b0, 1'b0, 8'h00});
        dir_rows.push_back('{ROW_BYTE, 12'h0FF, 1'b1, 1'b0, 1'b0, 8'h00});
        dir_rows.push_back('{ROW_BYTE, 12'h000, 1'b0, 1'b1, 1'b0, 8'h00});
        // base64url extreme values
        dir_rows.push_back('{ROW_MODE, 12'(mrte_pkg::MODE_B64URL), 1'b0, 1'b0, 1'b0, 8'h00});
        dir_rows.push_back('{ROW_BYTE, 12'h0FB, 1'b1, 1'b0, 1'b0, 8'h00});
        dir_rows.push_back('{ROW_BYTE, 12'h0FF, 1'b1, 1'b0, 1'b0, 8'h00});
        dir_rows.push_back('{ROW_BYTE, 12'h0BF, 1'b1, 1'b1, 1'b1, "-"});
        // base32 partial group of two, then a mode write drops a partial group
        dir_rows.push_back('{ROW_MODE, 12'(mrte_pkg::MODE_B32), 1'b0, 1'b0, 1'b0, 8'h00});
        dir_rows.push_back('{ROW_BYTE, 12'h000, 1'b1, 1'b0, 1'b0, 8'h00});
        dir_rows.push_back('{ROW_BYTE, 12'h0FF, 1'b1, 1'b1, 1'b1, "A"});
        dir_rows.push_back('{ROW_BYTE, 12'h055, 1'b1, 1'b0, 1'b0, 8'h00});
        dir_rows.push_back('{ROW_MODE, 12'(mrte_pkg::MODE_B16), 1'b0, 1'b0, 1'b0, 8'h00});
        // base16 with a tight wrap of one column
        dir_rows.push_back('{ROW_WRAP, 12'd1, 1'b0, 1'b0, 1'b0, 8'h00});
        dir_rows.push_back('{ROW_BYTE, 12'h0A5, 1'b1, 1'b0, 1'b1, "A"});
        dir_rows.push_back('{ROW_BYTE, 12'h000, 1'b0, 1'b1, 1'b1, mrte_pkg::CHAR_NL});
        // z85 with a length error, wrap off
        dir_rows.push_back('{ROW_WRAP, 12'd0, 1'b0, 1'b0, 1'b0, 8'h00});
        dir_rows.push_back('{ROW_MODE, 12'(mrte_pkg::MODE_Z85), 1'b0, 1'b0, 1'b0, 8'h00});
        dir_rows.push_back('{ROW_BYTE, 12'h086, 1'b1, 1'b0, 1'b0, 8'h00});
        dir_rows.push_back('{ROW_BYTE, 12'h04F, 1'b1, 1'b1, 1'b1, mrte_pkg::CHAR_NL});
        // bit strings at the widest wrap
        dir_rows.push_back('{ROW_WRAP, 12'd4095, 1'b0, 1'b0, 1'b0, 8'h00});
        dir_rows.push_back('{ROW_MODE, 12'(mrte_pkg::MODE_BITS_M), 1'b0, 1'b0, 1'b0, 8'h00});
        dir_rows.push_back('{ROW_BYTE, 12'h080, 1'b1, 1'b1, 1'b1, "1"});

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        foreach (dir_rows[i]) run_row(dir_rows[i]);
        // lowering the wrap mid-line causes one newline before the next char
        write_reg(mrte_pkg::CFG_MODE, 12'(mrte_pkg::MODE_BITS_L));
        write_reg(mrte_pkg::CFG_WRAP, 12'd20);
        send_byte(8'h01, 1'b1, 1'b0);
        send_byte(8'hFE, 1'b1, 1'b0);
        write_reg(mrte_pkg::CFG_WRAP, 12'd3);
        send_byte(8'h3C, 1'b1, 1'b1);

        // random streams, mostly with idling on both sides
        n_items = 0;
        while (n_items < 150) begin
            write_reg(mrte_pkg::CFG_MODE, 12'($urandom_range(0, 7)));
            case ($urandom_range(0, 3))
                0: write_reg(mrte_pkg::CFG_WRAP, 12'd0);
                1: write_reg(mrte_pkg::CFG_WRAP, 12'($urandom_range(1, 12)));
                2: write_reg(mrte_pkg::CFG_WRAP, 12'd4095);
                default: write_reg(mrte_pkg::CFG_WRAP, 12'($urandom_range(13, 80)));
            endcase
            stall_en = ($urandom_range(0, 3) != 0);
            len = $urandom_range(0, 14);
            for (int k = 0; k < len; k++) begin
                burst = $urandom_range(0, 4);
                if (burst == 0) begin
                    idle_input();
                    repeat ($urandom_range(1, 6)) @(posedge aclk);
                end
                // occasional idle transaction without a byte
                if ($urandom_range(0, 9) == 0) send_byte(8'($urandom), 1'b0, 1'b0);
                else send_byte(8'($urandom), 1'b1, 1'b0);
                n_items++;
            end
            if ($urandom_range(0, 1) == 0) send_byte(8'($urandom), 1'b1, 1'b1);
            else send_byte(8'($urandom), 1'b0, 1'b1);
            n_items++;
        end

        stall_en = 1'b0;
        wait_quiet();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
